[sv/i2cbb_pkg.sv]
// i2cbb_pkg: shared types and codes for the i2c bit-bang master unit
// command codes, datapath phase operations, controller/datapath link structs
// no dependencies
package i2cbb_pkg;

   localparam int CmdWidth  = 3;
   localparam int ByteWidth = 8;

   localparam logic [CmdWidth-1:0] CMD_START     = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_STOP      = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_WRITE     = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_READ      = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_SEND_ACK  = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_RECV_ACK  = 3'd5;

   typedef enum logic [2:0] {
      OP_SDA_ONE  = 3'd0,
      OP_SDA_ZERO = 3'd1,
      OP_SDA_WBIT = 3'd2,
      OP_SDA_ACK  = 3'd3,
      OP_SCL_ONE  = 3'd4,
      OP_SCL_ZERO = 3'd5
   } op_type;

   typedef struct packed {
      logic   load;
      logic   issue;
      op_type op;
      logic   sample;
      logic   last;
      logic   rd_take;
      logic   ack_take;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_status_type;

endpackage

[sv/i2cbb_ctrl.sv]
// i2cbb_ctrl: command sequencer for the i2c bit-bang master unit
// walks the pin phases of each command and issues one phase per free output slot
// depends on i2cbb_pkg
module i2cbb_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [i2cbb_pkg::CmdWidth-1:0]   req_cmd,
   input  i2cbb_pkg::ctl_status_type        status,
   output i2cbb_pkg::ctl_cmd_type           cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [i2cbb_pkg::CmdWidth-1:0]     cmd_ff, cmd_in;
   logic [1:0]                         sub_ff, sub_in;
   logic [2:0]                         bit_ff, bit_in;

   logic                               accept;
   logic                               cmd_ok;
   i2cbb_pkg::op_type                  op;
   logic                               sample;
   logic                               last;
   logic                               rd_take;
   logic                               ack_take;
   logic                               last_bit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign cmd_ok    = req_cmd inside {i2cbb_pkg::CMD_START, i2cbb_pkg::CMD_STOP,
                                      i2cbb_pkg::CMD_WRITE, i2cbb_pkg::CMD_READ,
                                      i2cbb_pkg::CMD_SEND_ACK, i2cbb_pkg::CMD_RECV_ACK};
   assign last_bit  = (bit_ff == 3'd7);

   // phase table
   always_comb begin
      op       = i2cbb_pkg::OP_SCL_ZERO;
      sample   = 1'b0;
      last     = 1'b0;
      rd_take  = 1'b0;
      ack_take = 1'b0;
      case (cmd_ff)
         i2cbb_pkg::CMD_START: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_ONE;
               2'd1:    op = i2cbb_pkg::OP_SCL_ONE;
               2'd2:    op = i2cbb_pkg::OP_SDA_ZERO;
               default: begin
                  op   = i2cbb_pkg::OP_SCL_ZERO;
                  last = 1'b1;
               end
            endcase
         end
         i2cbb_pkg::CMD_STOP: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_ZERO;
               2'd1:    op = i2cbb_pkg::OP_SCL_ONE;
               default: begin
                  op   = i2cbb_pkg::OP_SDA_ONE;
                  last = 1'b1;
               end
            endcase
         end
         i2cbb_pkg::CMD_WRITE: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_WBIT;
               2'd1:    op = i2cbb_pkg::OP_SCL_ONE;
               default: begin
                  op   = i2cbb_pkg::OP_SCL_ZERO;
                  last = last_bit;
               end
            endcase
         end
         i2cbb_pkg::CMD_READ: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_ONE;
               2'd1: begin
                  op     = i2cbb_pkg::OP_SCL_ONE;
                  sample = 1'b1;
               end
               default: begin
                  op      = i2cbb_pkg::OP_SCL_ZERO;
                  last    = last_bit;
                  rd_take = last_bit;
               end
            endcase
         end
         i2cbb_pkg::CMD_SEND_ACK: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_ACK;
               2'd1:    op = i2cbb_pkg::OP_SCL_ONE;
               default: begin
                  op   = i2cbb_pkg::OP_SCL_ZERO;
                  last = 1'b1;
               end
            endcase
         end
         i2cbb_pkg::CMD_RECV_ACK: begin
            case (sub_ff)
               2'd0:    op = i2cbb_pkg::OP_SDA_ONE;
               2'd1: begin
                  op     = i2cbb_pkg::OP_SCL_ONE;
                  sample = 1'b1;
               end
               default: begin
                  op       = i2cbb_pkg::OP_SCL_ZERO;
                  last     = 1'b1;
                  ack_take = 1'b1;
               end
            endcase
         end
         default: op = i2cbb_pkg::OP_SCL_ZERO;
      endcase
   end

   always_comb begin
      cmd.load     = accept;
      cmd.issue    = (state_ff == ST_RUN) && status.out_free;
      cmd.op       = op;
      cmd.sample   = sample;
      cmd.last     = last;
      cmd.rd_take  = rd_take;
      cmd.ack_take = ack_take;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && cmd_ok) begin
               state_in = ST_RUN;
               cmd_in   = req_cmd;
               sub_in   = 2'd0;
               bit_in   = 3'd0;
            end
         end
         ST_RUN: begin
            if (cmd.issue) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else if (sub_ff == 2'd2 && cmd_ff == i2cbb_pkg::CMD_READ) begin
                  sub_in = 2'd1;
                  bit_in = bit_ff + 3'd1;
               end else if (sub_ff == 2'd2 && cmd_ff == i2cbb_pkg::CMD_WRITE) begin
                  sub_in = 2'd0;
                  bit_in = bit_ff + 3'd1;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      sub_ff <= sub_in;
      bit_ff <= bit_in;
   end

   a_issue_only_run: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> state_ff == ST_RUN)
      else $error("phase issued outside run");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.issue && cmd.last |=> state_ff == ST_IDLE)
      else $error("no return to idle after last phase");

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && sub_ff == 2'd3 |-> cmd_ff == i2cbb_pkg::CMD_START)
      else $error("fourth phase slot outside start");

endmodule

[sv/i2cbb_datapath.sv]
// i2cbb_datapath: pin levels, latched transaction fields and output register
// executes the phase operations issued by i2cbb_ctrl
// depends on i2cbb_pkg
module i2cbb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  i2cbb_pkg::ctl_cmd_type             cmd,
   output i2cbb_pkg::ctl_status_type          status,
   input  logic [i2cbb_pkg::ByteWidth-1:0]    req_write_data,
   input  logic                               req_ack_out,
   input  logic [i2cbb_pkg::ByteWidth-1:0]    req_bus_bits,
   input  logic                               req_bus_ack,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_scl,
   output logic                               rsp_sda,
   output logic                               rsp_sample_point,
   output logic [i2cbb_pkg::ByteWidth-1:0]    rsp_read_data,
   output logic                               rsp_ack_in,
   output logic                               rsp_last
);

   logic                              scl_lvl_ff, scl_lvl_in;
   logic                              sda_lvl_ff, sda_lvl_in;
   logic [i2cbb_pkg::ByteWidth-1:0]   wdata_ff, wdata_in;
   logic                              ack_out_ff;
   logic [i2cbb_pkg::ByteWidth-1:0]   bus_bits_ff;
   logic                              bus_ack_ff;
   logic                              valid_ff, valid_in;
   logic                              scl_ff, sda_ff, samp_ff, ack_ff, last_ff;
   logic [i2cbb_pkg::ByteWidth-1:0]   rd_ff;

   assign status.out_free = !valid_ff || !rsp_stall;

   always_comb begin
      scl_lvl_in = scl_lvl_ff;
      sda_lvl_in = sda_lvl_ff;
      wdata_in   = cmd.load ? req_write_data : wdata_ff;
      if (cmd.issue) begin
         case (cmd.op)
            i2cbb_pkg::OP_SDA_ONE:  sda_lvl_in = 1'b1;
            i2cbb_pkg::OP_SDA_ZERO: sda_lvl_in = 1'b0;
            i2cbb_pkg::OP_SDA_WBIT: begin
               sda_lvl_in = wdata_ff[i2cbb_pkg::ByteWidth-1];
               wdata_in   = {wdata_ff[i2cbb_pkg::ByteWidth-2:0], 1'b0};
            end
            i2cbb_pkg::OP_SDA_ACK:  sda_lvl_in = ack_out_ff;
            i2cbb_pkg::OP_SCL_ONE:  scl_lvl_in = 1'b1;
            i2cbb_pkg::OP_SCL_ZERO: scl_lvl_in = 1'b0;
            default:                scl_lvl_in = scl_lvl_ff;
         endcase
      end
      valid_in = cmd.issue || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_lvl_ff <= 1'b1;
         sda_lvl_ff <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         scl_lvl_ff <= scl_lvl_in;
         sda_lvl_ff <= sda_lvl_in;
         valid_ff   <= valid_in;
      end
      wdata_ff <= wdata_in;
      if (cmd.load) begin
         ack_out_ff  <= req_ack_out;
         bus_bits_ff <= req_bus_bits;
         bus_ack_ff  <= req_bus_ack;
      end
      if (cmd.issue) begin
         scl_ff  <= scl_lvl_in;
         sda_ff  <= sda_lvl_in;
         samp_ff <= cmd.sample;
         rd_ff   <= cmd.rd_take ? bus_bits_ff : '0;
         ack_ff  <= cmd.ack_take && bus_ack_ff;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_scl          = scl_ff;
   assign rsp_sda          = sda_ff;
   assign rsp_sample_point = samp_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_ack_in       = ack_ff;
   assign rsp_last         = last_ff;

   a_sample_scl_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_point |-> rsp_scl)
      else $error("sample point with scl low");

   a_rd_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != '0 || rsp_ack_in) |-> rsp_last)
      else $error("read data or ack outside last phase");

endmodule

[sv/i2c_bitbang_master_unit.sv]
// i2c_bitbang_master_unit: i2c master bit sequencer, top level
// instantiates i2cbb_ctrl and i2cbb_datapath; depends on i2cbb_pkg
//
//   channel  handshake            payload
//   req      req_valid/req_stall  cmd, write_data, ack_out, bus_bits, bus_ack
//   rsp      rsp_valid/rsp_stall  scl, sda, sample_point, read_data, ack_in, last
//
// one pin phase out per cycle while rsp is not stalled: start 4, stop 3,
// write 24, read 17, send/receive ack 3 phases, set by the phase sequencer;
// each transaction is first taken in the idle state. unused codes are taken
// and produce nothing. every stalled rsp cycle holds the sequencer; reset
// releases both lines.
module i2c_bitbang_master_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [i2cbb_pkg::CmdWidth-1:0]     req_cmd,
   input  logic [i2cbb_pkg::ByteWidth-1:0]    req_write_data,
   input  logic                               req_ack_out,
   input  logic [i2cbb_pkg::ByteWidth-1:0]    req_bus_bits,
   input  logic                               req_bus_ack,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_scl,
   output logic                               rsp_sda,
   output logic                               rsp_sample_point,
   output logic [i2cbb_pkg::ByteWidth-1:0]    rsp_read_data,
   output logic                               rsp_ack_in,
   output logic                               rsp_last
);

   i2cbb_pkg::ctl_cmd_type     cmd;
   i2cbb_pkg::ctl_status_type  status;

   i2cbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd)
   );

   i2cbb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_write_data   (req_write_data),
      .req_ack_out      (req_ack_out),
      .req_bus_bits     (req_bus_bits),
      .req_bus_ack      (req_bus_ack),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl          (rsp_scl),
      .rsp_sda          (rsp_sda),
      .rsp_sample_point (rsp_sample_point),
      .rsp_read_data    (rsp_read_data),
      .rsp_ack_in       (rsp_ack_in),
      .rsp_last         (rsp_last)
   );

endmodule
